// ===== sv/bda_pkg.sv =====
// ----------------------------------------------------------------------------
// bda_pkg
// Shared sizes, codes and small helpers of the banker's deadlock-avoidance
// unit.
// ----------------------------------------------------------------------------
package bda_pkg;

    // sizing
    localparam int PROCESSES  = 5;
    localparam int TYPES      = 3;
    localparam int COUNT_BITS = 8;

    localparam int ROW_W  = TYPES * COUNT_BITS;              // packed row
    localparam int PROC_W = 3;                               // process field
    localparam int IDX_W  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int SUM_W  = COUNT_BITS + $clog2(PROCESSES + 1); // sums, work
    localparam int CNT_W  = $clog2(PROCESSES + 1);
    localparam int SEQ_W  = PROC_W * PROCESSES;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(PROCESSES - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(PROCESSES);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(PROCESSES - 1);
    localparam logic [PROC_W:0]  PROC_LIMIT = (PROC_W + 1)'(PROCESSES);

    // register map (word index = paddr[ADDR_W-1:2])
    localparam logic [ADDR_W-3:0] REG_TOTAL = '0;

    // commands
    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_REQUEST = 2'd1,
        CMD_CHECK   = 2'd2
    } t_cmd;

    // result status codes
    typedef enum logic [2:0] {
        ST_LOADED      = 3'd0,
        ST_LOAD_REJECT = 3'd1,
        ST_GRANTED     = 3'd2,
        ST_EXCEEDS     = 3'd3,
        ST_INSUFF      = 3'd4,
        ST_ROLLED_BACK = 3'd5,
        ST_SAFE        = 3'd6,
        ST_UNSAFE      = 3'd7
    } t_status;

    // widen one count to sum width
    function automatic logic [SUM_W-1:0] zext(input logic [COUNT_BITS-1:0] x);
        zext = SUM_W'(x);
    endfunction

    // process index as it appears in the safe sequence
    function automatic logic [PROC_W-1:0] idx_to_proc(input logic [IDX_W-1:0] i);
        idx_to_proc = PROC_W'(i);
    endfunction

    // process field within the table range
    function automatic logic proc_in_range(input logic [PROC_W-1:0] p);
        proc_in_range = ({1'b0, p} < PROC_LIMIT);
    endfunction

endpackage

// ===== sv/bankers_deadlock_avoidance.sv =====
// Loads, and requests rejected up front, pass from the evaluate state to the
// result state; requests that pass and safety checks also run the start, scan
// and finish states, and the safety scan checks one process row per cycle
// through a single need/work compare unit. One word at a time: stall stays
// high until the result enters the output register.
// Reset (synchronous, active low) clears totals, claim and allocation tables.
// ----------------------------------------------------------------------------
// bankers_deadlock_avoidance
// Banker's algorithm unit: keeps claim and allocation rows per process,
// loads rows, grants requests only into safe states, checks safety.
// ----------------------------------------------------------------------------
module bankers_deadlock_avoidance (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input words
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_cmd,
    input  logic [bda_pkg::PROC_W-1:0]        i_process,
    input  logic [bda_pkg::ROW_W-1:0]         i_amount,
    input  logic [bda_pkg::ROW_W-1:0]         i_claim,
    // result words
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [2:0]                        o_status,
    output logic [bda_pkg::SEQ_W-1:0]         o_safe_sequence,
    output logic [bda_pkg::ROW_W-1:0]         o_available,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bda_pkg::ADDR_W-1:0]        paddr,
    input  logic [bda_pkg::DATA_W-1:0]        pwdata,
    output logic [bda_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EVAL   = 6'b000010,
        S_START  = 6'b000100,
        S_SCAN   = 6'b001000,
        S_FINISH = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // item registers
    logic [1:0]                         r_cmd, n_cmd;
    logic [bda_pkg::PROC_W-1:0]         r_proc, n_proc;
    logic [bda_pkg::IDX_W-1:0]          r_pidx, n_pidx;
    logic [bda_pkg::ROW_W-1:0]          r_amount, n_amount;
    logic [bda_pkg::ROW_W-1:0]          r_claim, n_claim;
    logic [bda_pkg::IDX_W-1:0]          r_idx, n_idx;
    logic [2:0]                         r_status, n_status;

    // tables and running sums
    logic [bda_pkg::ROW_W-1:0]          r_claim_tab [bda_pkg::PROCESSES];
    logic [bda_pkg::ROW_W-1:0]          r_alloc_tab [bda_pkg::PROCESSES];
    logic [bda_pkg::SUM_W-1:0]          r_sum [bda_pkg::TYPES];
    logic [bda_pkg::SUM_W-1:0]          n_sum [bda_pkg::TYPES];
    logic [bda_pkg::ROW_W-1:0]          r_total;

    // safety scan state
    logic [bda_pkg::SUM_W-1:0]          r_work [bda_pkg::TYPES];
    logic [bda_pkg::SUM_W-1:0]          n_work [bda_pkg::TYPES];
    logic [bda_pkg::PROCESSES-1:0]      r_done, n_done;
    logic [bda_pkg::CNT_W-1:0]          r_count, n_count;
    logic [bda_pkg::SEQ_W-1:0]          r_seq, n_seq;

    // output register
    logic                               r_out_valid, n_out_valid;
    logic [2:0]                         r_out_status, n_out_status;
    logic [bda_pkg::SEQ_W-1:0]          r_out_seq, n_out_seq;
    logic [bda_pkg::ROW_W-1:0]          r_out_avail, n_out_avail;

    // table write port
    logic                               tab_we_claim;
    logic                               tab_we_alloc;
    logic [bda_pkg::ROW_W-1:0]          tab_wclaim;
    logic [bda_pkg::ROW_W-1:0]          tab_walloc;

    // lane values
    logic [bda_pkg::ROW_W-1:0]          rd_claim, rd_alloc;
    logic [bda_pkg::ROW_W-1:0]          avail_all;
    logic [bda_pkg::ROW_W-1:0]          row_add, row_sub;
    logic [bda_pkg::SUM_W-1:0]          work_add [bda_pkg::TYPES];
    logic [bda_pkg::SUM_W-1:0]          sum_excl [bda_pkg::TYPES];
    logic [bda_pkg::SUM_W-1:0]          sum_load [bda_pkg::TYPES];
    logic [bda_pkg::SUM_W-1:0]          sum_grant [bda_pkg::TYPES];
    logic [bda_pkg::SUM_W-1:0]          sum_back [bda_pkg::TYPES];
    logic                               load_ok, fit_avail, fit_need, fits;
    logic                               cfg_write;

    // single read port on both tables
    assign rd_claim = r_claim_tab[r_idx];
    assign rd_alloc = r_alloc_tab[r_idx];

    // per-type compare / add unit
    always_comb begin
        logic [bda_pkg::COUNT_BITS-1:0] a_l, c_l, tc_l, ta_l, tot_l, need_l, av_x;
        logic [bda_pkg::SUM_W-1:0]      tot_w, diff;
        load_ok   = bda_pkg::proc_in_range(r_proc);
        fit_avail = 1'b1;
        fit_need  = 1'b1;
        fits      = !r_done[r_idx];
        avail_all = '0;
        row_add   = '0;
        row_sub   = '0;
        for (int t = 0; t < bda_pkg::TYPES; t++) begin
            a_l   = r_amount[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS];
            c_l   = r_claim[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS];
            tc_l  = rd_claim[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS];
            ta_l  = rd_alloc[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS];
            tot_l = r_total[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS];
            tot_w = bda_pkg::zext(tot_l);
            // availability over all processes, saturating
            diff  = tot_w - r_sum[t];
            avail_all[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS] =
                (tot_w >= r_sum[t]) ? diff[bda_pkg::COUNT_BITS-1:0] : '0;
            // availability ignoring the addressed row
            sum_excl[t] = r_sum[t] - bda_pkg::zext(ta_l);
            diff  = tot_w - sum_excl[t];
            av_x  = (tot_w >= sum_excl[t]) ? diff[bda_pkg::COUNT_BITS-1:0] : '0;
            need_l = (tc_l >= ta_l) ? (tc_l - ta_l) : '0;
            if (a_l > c_l || a_l > av_x) begin
                load_ok = 1'b0;
            end
            if (a_l > avail_all[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS]) begin
                fit_avail = 1'b0;
            end
            if (a_l > need_l) begin
                fit_need = 1'b0;
            end
            if (bda_pkg::zext(need_l) > r_work[t]) begin
                fits = 1'b0;
            end
            work_add[t]  = r_work[t] + bda_pkg::zext(ta_l);
            sum_load[t]  = sum_excl[t] + bda_pkg::zext(a_l);
            sum_grant[t] = r_sum[t] + bda_pkg::zext(a_l);
            sum_back[t]  = r_sum[t] - bda_pkg::zext(a_l);
            row_add[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS] = ta_l + a_l;
            row_sub[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS] = ta_l - a_l;
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_proc       = r_proc;
        n_pidx       = r_pidx;
        n_amount     = r_amount;
        n_claim      = r_claim;
        n_idx        = r_idx;
        n_status     = r_status;
        n_sum        = r_sum;
        n_work       = r_work;
        n_done       = r_done;
        n_count      = r_count;
        n_seq        = r_seq;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_seq    = r_out_seq;
        n_out_avail  = r_out_avail;
        tab_we_claim = 1'b0;
        tab_we_alloc = 1'b0;
        tab_wclaim   = r_claim;
        tab_walloc   = r_amount;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd    = i_cmd;
                    n_proc   = i_process;
                    n_amount = i_amount;
                    n_claim  = i_claim;
                    n_pidx   = bda_pkg::proc_in_range(i_process) ?
                               i_process[bda_pkg::IDX_W-1:0] : '0;
                    n_idx    = bda_pkg::proc_in_range(i_process) ?
                               i_process[bda_pkg::IDX_W-1:0] : '0;
                    n_seq    = '0;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                unique case (r_cmd)
                    bda_pkg::CMD_LOAD: begin
                        n_state = S_RESULT;
                        if (load_ok) begin
                            tab_we_claim = 1'b1;
                            tab_we_alloc = 1'b1;
                            n_sum        = sum_load;
                            n_status     = bda_pkg::ST_LOADED;
                        end else begin
                            n_status     = bda_pkg::ST_LOAD_REJECT;
                        end
                    end
                    bda_pkg::CMD_REQUEST: begin
                        if (!bda_pkg::proc_in_range(r_proc)) begin
                            n_status = bda_pkg::ST_EXCEEDS;
                            n_state  = S_RESULT;
                        end else if (!fit_avail) begin
                            n_status = bda_pkg::ST_INSUFF;
                            n_state  = S_RESULT;
                        end else if (!fit_need) begin
                            n_status = bda_pkg::ST_EXCEEDS;
                            n_state  = S_RESULT;
                        end else begin
                            // tentative grant
                            tab_we_alloc = 1'b1;
                            tab_walloc   = row_add;
                            n_sum        = sum_grant;
                            n_state      = S_START;
                        end
                    end
                    default: begin
                        n_state = S_START;
                    end
                endcase
            end
            S_START: begin
                for (int t = 0; t < bda_pkg::TYPES; t++) begin
                    n_work[t] = bda_pkg::zext(
                        avail_all[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS]);
                end
                n_done  = '0;
                n_count = '0;
                n_seq   = '0;
                n_idx   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // one row per cycle; a pick restarts from the lowest index
                if (fits) begin
                    n_work        = work_add;
                    n_done[r_idx] = 1'b1;
                    n_count       = r_count + 1'b1;
                    for (int k = 0; k < bda_pkg::PROCESSES; k++) begin
                        if (r_count == bda_pkg::CNT_W'(k)) begin
                            n_seq[k*bda_pkg::PROC_W +: bda_pkg::PROC_W] =
                                bda_pkg::idx_to_proc(r_idx);
                        end
                    end
                    if (r_count == bda_pkg::LAST_COUNT) begin
                        n_idx   = r_pidx;
                        n_state = S_FINISH;
                    end else begin
                        n_idx   = '0;
                    end
                end else if (r_idx == bda_pkg::LAST_IDX) begin
                    n_idx   = r_pidx;
                    n_state = S_FINISH;
                end else begin
                    n_idx   = r_idx + 1'b1;
                end
            end
            S_FINISH: begin
                n_state = S_RESULT;
                if (r_cmd == bda_pkg::CMD_REQUEST) begin
                    if (r_count == bda_pkg::FULL_COUNT) begin
                        n_status = bda_pkg::ST_GRANTED;
                    end else begin
                        // undo the tentative grant
                        tab_we_alloc = 1'b1;
                        tab_walloc   = row_sub;
                        n_sum        = sum_back;
                        n_seq        = '0;
                        n_status     = bda_pkg::ST_ROLLED_BACK;
                    end
                end else if (r_count == bda_pkg::FULL_COUNT) begin
                    n_status = bda_pkg::ST_SAFE;
                end else begin
                    n_seq    = '0;
                    n_status = bda_pkg::ST_UNSAFE;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_seq    = r_seq;
                    n_out_avail  = avail_all;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // configuration write
    assign cfg_write = psel && penable && pwrite &&
                       (paddr[bda_pkg::ADDR_W-1:2] == bda_pkg::REG_TOTAL);

    // control, sums and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            for (int t = 0; t < bda_pkg::TYPES; t++) begin
                r_sum[t] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_sum       <= n_sum;
            if (cfg_write) begin
                r_total <= pwdata[bda_pkg::ROW_W-1:0];
            end
        end
    end

    // tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < bda_pkg::PROCESSES; p++) begin
                r_claim_tab[p] <= '0;
                r_alloc_tab[p] <= '0;
            end
        end else begin
            if (tab_we_claim) begin
                r_claim_tab[r_idx] <= tab_wclaim;
            end
            if (tab_we_alloc) begin
                r_alloc_tab[r_idx] <= tab_walloc;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_proc       <= n_proc;
        r_pidx       <= n_pidx;
        r_amount     <= n_amount;
        r_claim      <= n_claim;
        r_idx        <= n_idx;
        r_status     <= n_status;
        r_work       <= n_work;
        r_done       <= n_done;
        r_count      <= n_count;
        r_seq        <= n_seq;
        r_out_status <= n_out_status;
        r_out_seq    <= n_out_seq;
        r_out_avail  <= n_out_avail;
    end

    // ports
    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_safe_sequence = r_out_seq;
    assign o_available     = r_out_avail;
    assign pready          = 1'b1;
    assign prdata          = (paddr[bda_pkg::ADDR_W-1:2] == bda_pkg::REG_TOTAL) ?
                             bda_pkg::DATA_W'(r_total) : '0;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the banker's deadlock-avoidance unit. A built-in
// model of the claim and allocation tables predicts status, safe order and
// availability for every accepted word. Directed cases run first, then
// random load/request/check traffic over several total settings, with
// random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] CMD_SPARE = 2'd3;   // unused code, behaves as a check
    localparam int DRAIN_CYCLES    = 10 + 4 + bda_pkg::PROCESSES * bda_pkg::PROCESSES;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 155;

    typedef struct packed {
        bda_pkg::t_status                 status;
        logic [bda_pkg::SEQ_W-1:0]        order;
        logic [bda_pkg::ROW_W-1:0]        avail;
    } t_verdict;

    // DUT connections
    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic [1:0]                     i_cmd;
    logic [bda_pkg::PROC_W-1:0]     i_process;
    logic [bda_pkg::ROW_W-1:0]      i_amount;
    logic [bda_pkg::ROW_W-1:0]      i_claim;
    logic                           o_valid;
    logic                           i_stall;
    logic [2:0]                     o_status;
    logic [bda_pkg::SEQ_W-1:0]      o_safe_sequence;
    logic [bda_pkg::ROW_W-1:0]      o_available;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [bda_pkg::ADDR_W-1:0]     paddr;
    logic [bda_pkg::DATA_W-1:0]     pwdata;
    logic [bda_pkg::DATA_W-1:0]     prdata;
    logic                           pready;

    // model copy of the unit's state
    logic [bda_pkg::ROW_W-1:0] totals_m;
    logic [bda_pkg::ROW_W-1:0] claim_m [bda_pkg::PROCESSES];
    logic [bda_pkg::ROW_W-1:0] alloc_m [bda_pkg::PROCESSES];

    t_verdict awaited[$];
    int errors = 0;
    int tally [8] = '{default: 0};
    int settings_written = 0;
    int stall_pct = 0;
    int gap_max = 0;
    int burst_left = 0;

    bankers_deadlock_avoidance dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_process       (i_process),
        .i_amount        (i_amount),
        .i_claim         (i_claim),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_safe_sequence (o_safe_sequence),
        .o_available     (o_available),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard limit on run time
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // model of the unit
    // ------------------------------------------------------------------
    function automatic int unsigned lane_of(input logic [bda_pkg::ROW_W-1:0] row,
                                            input int t);
        return 32'(row[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS]);
    endfunction

    // units of type t left over, not counting process skip
    function automatic int unsigned free_units(input int t, input int skip);
        int unsigned sum;
        int unsigned tot;
        sum = 0;
        tot = lane_of(totals_m, t);
        for (int p = 0; p < bda_pkg::PROCESSES; p++)
            if (p != skip) sum += lane_of(alloc_m[p], t);
        return (tot >= sum) ? tot - sum : 0;
    endfunction

    function automatic int unsigned need_of(input int p, input int t);
        int unsigned c;
        int unsigned a;
        c = lane_of(claim_m[p], t);
        a = lane_of(alloc_m[p], t);
        return (c >= a) ? c - a : 0;
    endfunction

    function automatic logic [bda_pkg::ROW_W-1:0] pack_free();
        logic [bda_pkg::ROW_W-1:0] v;
        v = '0;
        for (int t = 0; t < bda_pkg::TYPES; t++)
            v[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS] =
                bda_pkg::COUNT_BITS'(free_units(t, bda_pkg::PROCESSES));
        return v;
    endfunction

    // lowest-first safety scan; returns 1 when every process can finish
    function automatic bit find_safe_order(output logic [bda_pkg::SEQ_W-1:0] order);
        int unsigned work [bda_pkg::TYPES];
        bit finished [bda_pkg::PROCESSES];
        int found;
        bit fits;
        order = '0;
        found = 0;
        for (int t = 0; t < bda_pkg::TYPES; t++)
            work[t] = free_units(t, bda_pkg::PROCESSES);
        for (int p = 0; p < bda_pkg::PROCESSES; p++) finished[p] = 1'b0;
        for (int pass = 0; pass < bda_pkg::PROCESSES; pass++) begin
            for (int p = 0; p < bda_pkg::PROCESSES; p++) begin
                fits = !finished[p];
                for (int t = 0; t < bda_pkg::TYPES; t++)
                    if (need_of(p, t) > work[t]) fits = 1'b0;
                if (fits) begin
                    for (int t = 0; t < bda_pkg::TYPES; t++)
                        work[t] += lane_of(alloc_m[p], t);
                    finished[p] = 1'b1;
                    order[found*bda_pkg::PROC_W +: bda_pkg::PROC_W] = bda_pkg::PROC_W'(p);
                    found++;
                    break;
                end
            end
        end
        return found == bda_pkg::PROCESSES;
    endfunction

    // update the model with one word and give the result it should cause
    function automatic t_verdict apply_word(input logic [1:0] cmd,
                                            input logic [bda_pkg::PROC_W-1:0] proc,
                                            input logic [bda_pkg::ROW_W-1:0] amount,
                                            input logic [bda_pkg::ROW_W-1:0] claim);
        t_verdict v;
        int p;
        bit ok;
        bit fit_avail;
        bit fit_need;
        int unsigned r;
        logic [bda_pkg::ROW_W-1:0] saved;
        logic [bda_pkg::SEQ_W-1:0] order;
        v.order = '0;
        p = int'(proc);
        case (cmd)
            bda_pkg::CMD_LOAD: begin
                v.status = bda_pkg::ST_LOAD_REJECT;
                if (p < bda_pkg::PROCESSES) begin
                    ok = 1'b1;
                    for (int t = 0; t < bda_pkg::TYPES; t++) begin
                        r = lane_of(amount, t);
                        if (r > lane_of(claim, t) || r > free_units(t, p)) ok = 1'b0;
                    end
                    if (ok) begin
                        claim_m[p] = claim;
                        alloc_m[p] = amount;
                        v.status = bda_pkg::ST_LOADED;
                    end
                end
            end
            bda_pkg::CMD_REQUEST: begin
                v.status = bda_pkg::ST_EXCEEDS;
                if (p < bda_pkg::PROCESSES) begin
                    fit_avail = 1'b1;
                    fit_need = 1'b1;
                    for (int t = 0; t < bda_pkg::TYPES; t++) begin
                        r = lane_of(amount, t);
                        if (r > free_units(t, bda_pkg::PROCESSES)) fit_avail = 1'b0;
                        if (r > need_of(p, t)) fit_need = 1'b0;
                    end
                    if (!fit_avail) begin
                        v.status = bda_pkg::ST_INSUFF;
                    end else if (fit_need) begin
                        // grant tentatively, undo if the state turns unsafe
                        saved = alloc_m[p];
                        for (int t = 0; t < bda_pkg::TYPES; t++)
                            alloc_m[p][t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS] =
                                saved[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS] +
                                amount[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS];
                        if (find_safe_order(order)) begin
                            v.status = bda_pkg::ST_GRANTED;
                            v.order = order;
                        end else begin
                            alloc_m[p] = saved;
                            v.status = bda_pkg::ST_ROLLED_BACK;
                        end
                    end
                end
            end
            default: begin
                if (find_safe_order(order)) begin
                    v.status = bda_pkg::ST_SAFE;
                    v.order = order;
                end else begin
                    v.status = bda_pkg::ST_UNSAFE;
                end
            end
        endcase
        v.avail = pack_free();
        return v;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    function automatic logic [bda_pkg::ROW_W-1:0] pack_counts(input int c0, input int c1,
                                                              input int c2);
        return {bda_pkg::COUNT_BITS'(c2), bda_pkg::COUNT_BITS'(c1),
                bda_pkg::COUNT_BITS'(c0)};
    endfunction

    // sender bursts: random run length, random idle gap between runs
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(24, 1);
        gap = $urandom_range(gap_max, 0);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // present one word, hold it until accepted, then log its prediction
    task automatic send_word(input logic [1:0] cmd,
                             input logic [bda_pkg::PROC_W-1:0] proc,
                             input logic [bda_pkg::ROW_W-1:0] amount,
                             input logic [bda_pkg::ROW_W-1:0] claim);
        pace_sender();
        i_valid   <= 1'b1;
        i_cmd     <= cmd;
        i_process <= proc;
        i_amount  <= amount;
        i_claim   <= claim;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        awaited.push_back(apply_word(cmd, proc, amount, claim));
    endtask

    // wait for every outstanding result, then let the unit settle
    task automatic drain_results();
        i_valid <= 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write the totals register, then read it back
    task automatic write_totals(input logic [bda_pkg::ROW_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {bda_pkg::REG_TOTAL, 2'b00};
        pwdata  <= {(bda_pkg::DATA_W-bda_pkg::ROW_W)'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        totals_m = value;
        settings_written++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[bda_pkg::ROW_W-1:0] !== value) begin
            $display("%0t: totals readback mismatch: expected %06h, actual %06h",
                     $time, value, prdata[bda_pkg::ROW_W-1:0]);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // receiver stall pattern: runs of random length, stalled with stall_pct odds
    initial begin : receiver_stall
        int hold;
        hold = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                hold = $urandom_range(12, 1);
                i_stall <= ($urandom_range(99, 0) < stall_pct);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin : result_check
        t_verdict exp_v;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual status %0d",
                         $time, o_status);
                errors++;
            end else begin
                exp_v = awaited.pop_front();
                tally[exp_v.status]++;
                if (o_status !== exp_v.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, exp_v.status, o_status);
                    errors++;
                end
                if (o_safe_sequence !== exp_v.order) begin
                    $display("%0t: safe order mismatch: expected %04h, actual %04h",
                             $time, exp_v.order, o_safe_sequence);
                    errors++;
                end
                if (o_available !== exp_v.avail) begin
                    $display("%0t: availability mismatch: expected %06h, actual %06h",
                             $time, exp_v.avail, o_available);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // random traffic generator
    // ------------------------------------------------------------------
    function automatic void random_banking_word(output logic [1:0] cmd,
                                                output logic [bda_pkg::PROC_W-1:0] proc,
                                                output logic [bda_pkg::ROW_W-1:0] amount,
                                                output logic [bda_pkg::ROW_W-1:0] claim);
        int pick;
        int p;
        int unsigned c;
        int unsigned n;
        int unsigned f;
        int unsigned cap;
        int unsigned a;
        pick = $urandom_range(99, 0);
        p = $urandom_range(bda_pkg::PROCESSES - 1, 0);
        cmd = bda_pkg::CMD_CHECK;
        proc = bda_pkg::PROC_W'(p);
        amount = '0;
        claim = '0;
        if (pick < 18) begin
            // row load: claim within totals (rarely beyond), allocation mostly fits
            cmd = bda_pkg::CMD_LOAD;
            for (int t = 0; t < bda_pkg::TYPES; t++) begin
                c = (pick < 2) ? $urandom_range(255, 0)
                               : $urandom_range(lane_of(totals_m, t), 0);
                f = free_units(t, p);
                cap = (c < f) ? c : f;
                a = ($urandom_range(3, 0) == 0) ? $urandom_range(cap, 0)
                                               : $urandom_range(cap / 3, 0);
                if ($urandom_range(15, 0) == 0 && cap < 255) a = cap + 1;
                claim[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS]  =
                    bda_pkg::COUNT_BITS'(c);
                amount[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS] =
                    bda_pkg::COUNT_BITS'(a);
            end
        end else if (pick < 70) begin
            // request within need and availability, now and then one unit over
            cmd = bda_pkg::CMD_REQUEST;
            for (int t = 0; t < bda_pkg::TYPES; t++) begin
                n = need_of(p, t);
                f = free_units(t, bda_pkg::PROCESSES);
                cap = (n < f) ? n : f;
                a = $urandom_range(cap, 0);
                if ($urandom_range(19, 0) == 0 && cap < 255) a = cap + 1;
                amount[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS] =
                    bda_pkg::COUNT_BITS'(a);
            end
        end else if (pick < 80) begin
            cmd = (pick < 75) ? bda_pkg::CMD_CHECK : CMD_SPARE;
            proc = bda_pkg::PROC_W'($urandom());
            amount = bda_pkg::ROW_W'($urandom());
            claim = bda_pkg::ROW_W'($urandom());
        end else begin
            // noise: any field value
            cmd = 2'($urandom());
            proc = bda_pkg::PROC_W'($urandom());
            amount = bda_pkg::ROW_W'($urandom());
            claim = bda_pkg::ROW_W'($urandom());
        end
    endfunction

    function automatic logic [bda_pkg::ROW_W-1:0] make_totals(input int lo, input int hi);
        logic [bda_pkg::ROW_W-1:0] v;
        v = '0;
        for (int t = 0; t < bda_pkg::TYPES; t++)
            v[t*bda_pkg::COUNT_BITS +: bda_pkg::COUNT_BITS] =
                bda_pkg::COUNT_BITS'($urandom_range(hi, lo));
        return v;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // totals still zero after reset
    task automatic test_reset_state();
        send_word(bda_pkg::CMD_CHECK,   3'd0, '0, '0);
        send_word(bda_pkg::CMD_LOAD,    3'd2, '0, '1);
        send_word(bda_pkg::CMD_CHECK,   3'd4, '0, '0);
        send_word(bda_pkg::CMD_REQUEST, 3'd2, '0, '0);  // fits, but leaves an unsafe state
        send_word(bda_pkg::CMD_REQUEST, 3'd2, pack_counts(1, 0, 0), '0);
        send_word(bda_pkg::CMD_LOAD,    3'd2, '0, '0);
        drain_results();
    endtask

    // all totals at their maximum; rejects and out-of-range indexes
    task automatic test_full_totals();
        write_totals('1);
        send_word(bda_pkg::CMD_LOAD,    3'd1, pack_counts(0, 2, 0), pack_counts(0, 1, 0));
        send_word(bda_pkg::CMD_LOAD,    3'd0, '1, '1);
        send_word(bda_pkg::CMD_LOAD,    3'd1, pack_counts(0, 0, 1), '1);
        send_word(bda_pkg::CMD_LOAD,    3'd7, '0, '0);
        send_word(bda_pkg::CMD_REQUEST, 3'd5, '0, '0);
        send_word(bda_pkg::CMD_REQUEST, 3'd0, pack_counts(1, 0, 0), '0);
        send_word(CMD_SPARE,            3'd6, '1, '1);
        send_word(bda_pkg::CMD_LOAD,    3'd0, '0, '0);
        drain_results();
    endtask

    // textbook five-process state: grant, shortage, roll-back, over-need
    task automatic test_textbook_state();
        write_totals(pack_counts(10, 5, 7));
        send_word(bda_pkg::CMD_LOAD, 3'd0, pack_counts(0, 1, 0), pack_counts(7, 5, 3));
        send_word(bda_pkg::CMD_LOAD, 3'd1, pack_counts(2, 0, 0), pack_counts(3, 2, 2));
        send_word(bda_pkg::CMD_LOAD, 3'd2, pack_counts(3, 0, 2), pack_counts(9, 0, 2));
        send_word(bda_pkg::CMD_LOAD, 3'd3, pack_counts(2, 1, 1), pack_counts(2, 2, 2));
        send_word(bda_pkg::CMD_LOAD, 3'd4, pack_counts(0, 0, 2), pack_counts(4, 3, 3));
        send_word(bda_pkg::CMD_CHECK,   3'd0, '0, '0);
        send_word(bda_pkg::CMD_REQUEST, 3'd1, pack_counts(1, 0, 2), '0);
        send_word(bda_pkg::CMD_REQUEST, 3'd4, pack_counts(3, 3, 0), '0);
        send_word(bda_pkg::CMD_REQUEST, 3'd0, pack_counts(0, 2, 0), '0);
        send_word(bda_pkg::CMD_REQUEST, 3'd3, pack_counts(1, 0, 0), '0);
        // short on availability and over need at once: availability wins
        send_word(bda_pkg::CMD_REQUEST, 3'd4, pack_counts(9, 0, 0), '0);
        drain_results();
    endtask

    // totals dropped below the current allocations
    task automatic test_shrunken_totals();
        write_totals(pack_counts(1, 1, 1));
        send_word(bda_pkg::CMD_CHECK,   3'd0, '0, '0);
        send_word(bda_pkg::CMD_REQUEST, 3'd3, '0, '0);
        drain_results();
    endtask

    // random traffic over several total settings and idling profiles
    task automatic test_random_traffic();
        logic [1:0]                     cmd;
        logic [bda_pkg::PROC_W-1:0]     proc;
        logic [bda_pkg::ROW_W-1:0]      amount;
        logic [bda_pkg::ROW_W-1:0]      claim;
        logic [bda_pkg::ROW_W-1:0]      totals;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin totals = make_totals(4, 24);  stall_pct = 30; gap_max = 4;  end
                1: begin totals = make_totals(4, 24);  stall_pct = 0;  gap_max = 0;  end
                2: begin totals = make_totals(0, 255); stall_pct = 50; gap_max = 8;  end
                3: begin totals = '1;                  stall_pct = 20; gap_max = 2;  end
                4: begin totals = make_totals(0, 3);   stall_pct = 60; gap_max = 12; end
                5: begin totals = make_totals(8, 40);  stall_pct = 10; gap_max = 0;  end
                6: begin
                    totals = bda_pkg::ROW_W'($urandom()); stall_pct = 70; gap_max = 3;
                end
                default: begin
                    totals = make_totals(4, 16); stall_pct = 40; gap_max = 6;
                end
            endcase
            write_totals(totals);
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                random_banking_word(cmd, proc, amount, claim);
                send_word(cmd, proc, amount, claim);
            end
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_cmd     <= bda_pkg::CMD_LOAD;
        i_process <= '0;
        i_amount  <= '0;
        i_claim   <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        totals_m = '0;
        for (int p = 0; p < bda_pkg::PROCESSES; p++) begin
            claim_m[p] = '0;
            alloc_m[p] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        stall_pct = 25;
        gap_max = 3;
        test_reset_state();
        test_full_totals();
        test_textbook_state();
        test_shrunken_totals();
        test_random_traffic();
        drain_results();

        $display("Checked %0d loads, %0d load rejects, %0d grants, %0d roll-backs,",
                 tally[bda_pkg::ST_LOADED], tally[bda_pkg::ST_LOAD_REJECT],
                 tally[bda_pkg::ST_GRANTED], tally[bda_pkg::ST_ROLLED_BACK]);
        $display("%0d over-need, %0d short, %0d safe and %0d unsafe checks over %0d totals",
                 tally[bda_pkg::ST_EXCEEDS], tally[bda_pkg::ST_INSUFF],
                 tally[bda_pkg::ST_SAFE], tally[bda_pkg::ST_UNSAFE], settings_written);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
